>>> hw/rtl/process_queue_manager_unit_assert.svh
// Assertion macros for the process queue manager
`ifndef PROCESS_QUEUE_MANAGER_UNIT_ASSERT_SVH
`define PROCESS_QUEUE_MANAGER_UNIT_ASSERT_SVH

// Clocked assertion, disabled while reset is held
`define PQM_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`endif

>>> hw/rtl/pqm_pkg.sv
// ----------------------------------------------------------------------------
// pqm_pkg
// Codes and defaults shared by the process queue manager.
// ----------------------------------------------------------------------------
package pqm_pkg;

    localparam int MAX_PROCS_DEF = 16;

    localparam logic [2:0] OP_CREATE  = 3'd0;
    localparam logic [2:0] OP_DELETE  = 3'd1;
    localparam logic [2:0] OP_BLOCK   = 3'd2;
    localparam logic [2:0] OP_UNBLOCK = 3'd3;
    localparam logic [2:0] OP_SUSPEND = 3'd4;
    localparam logic [2:0] OP_RESUME  = 3'd5;
    localparam logic [2:0] OP_SETPRIO = 3'd6;
    localparam logic [2:0] OP_QUERY   = 3'd7;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_DUPLICATE = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    localparam logic [1:0] MODE_READY        = 2'd0;
    localparam logic [1:0] MODE_BLOCKED      = 2'd1;
    localparam logic [1:0] MODE_SUSP_READY   = 2'd2;
    localparam logic [1:0] MODE_SUSP_BLOCKED = 2'd3;

endpackage

>>> hw/rtl/process_queue_manager_unit.sv
// ----------------------------------------------------------------------------
// process_queue_manager_unit
// Process table with a priority-ordered ready queue and a FIFO wait queue.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one command word (opcode, proc_id, proc_class,
//   new_priority); m_ channel returns one result word per command (status,
//   entry fields, ready queue head and both queue lengths).
//   One command at a time: s_ready is high only while the unit is idle.
//   A command runs in steps: a full scan of the table finds the id and a
//   free slot, then a decide step; where the entry moves, it is pulled
//   out of its queue and then walked into the ready queue from the tail or
//   appended to the wait queue. The scan, pull and walk go one entry per
//   cycle. A new command is taken only after the result word is accepted.
//   The result is held in the unit's registers until m_ready; a stalled
//   receiver holds the unit in its result state and no new command is taken.
//   Reset clears all valid bits and both queue lengths; the table is then
//   empty and the first command may follow at once.
// ----------------------------------------------------------------------------
`include "process_queue_manager_unit_assert.svh"

module process_queue_manager_unit
    import pqm_pkg::*;
#(
    parameter int MAX_PROCS = MAX_PROCS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [2:0]        s_opcode,
    input  logic [7:0]        s_proc_id,
    input  logic              s_proc_class,
    input  logic signed [7:0] s_new_priority,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_status,
    output logic [1:0]        m_entry_state_out,
    output logic              m_entry_class_out,
    output logic signed [7:0] m_entry_priority_out,
    output logic              m_head_valid,
    output logic [7:0]        m_head_id,
    output logic [4:0]        m_ready_total,
    output logic [4:0]        m_wait_total
);

    localparam int IW = $clog2(MAX_PROCS);
    localparam int CW = $clog2(MAX_PROCS + 1);
    localparam logic [CW-1:0] LAST = CW'(MAX_PROCS - 1);

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_DECIDE, S_DROP, S_INSERT, S_OUT
    } state_t;

    state_t state_reg;

    logic              slot_used_reg  [MAX_PROCS];
    logic [7:0]        slot_ident_reg [MAX_PROCS];
    logic              slot_kind_reg  [MAX_PROCS];
    logic [1:0]        slot_mode_reg  [MAX_PROCS];
    logic signed [7:0] slot_prio_reg  [MAX_PROCS];
    logic [IW-1:0]     ready_order_reg[MAX_PROCS];
    logic [IW-1:0]     wait_order_reg [MAX_PROCS];
    logic [CW-1:0]     ready_len_reg, wait_len_reg;

    logic [2:0]        op_reg;
    logic [7:0]        id_reg;
    logic              cls_reg;
    logic signed [7:0] pri_reg;
    logic [CW-1:0]     idx_reg;
    logic              match_reg, free_found_reg, drop_hit_reg;
    logic [IW-1:0]     slot_reg, free_reg;
    logic [1:0]        status_reg, old_mode_reg, new_mode_reg;
    logic [1:0]        del_mode_reg;
    logic              del_kind_reg;
    logic signed [7:0] del_prio_reg;

    // walk helpers
    logic [IW-1:0] cur_i, nxt_i, prv_i;
    logic [CW-1:0] idx_inc, idx_dec, list_len;
    logic          drop_sel_ready, drop_hit, drop_last;
    logic [IW-1:0] drop_cur;
    logic [1:0]    next_mode;

    assign cur_i   = idx_reg[IW-1:0];
    assign idx_inc = idx_reg + CW'(1);
    assign idx_dec = idx_reg - CW'(1);
    assign nxt_i   = idx_inc[IW-1:0];
    assign prv_i   = idx_dec[IW-1:0];

    assign drop_sel_ready = (old_mode_reg == MODE_READY);
    assign list_len  = drop_sel_ready ? ready_len_reg : wait_len_reg;
    assign drop_cur  = drop_sel_ready ? ready_order_reg[cur_i] : wait_order_reg[cur_i];
    assign drop_hit  = drop_hit_reg || (drop_cur == slot_reg);
    assign drop_last = (idx_inc >= list_len);

    always_comb begin
        next_mode = slot_mode_reg[slot_reg];
        case (op_reg)
            OP_BLOCK: begin
                if (next_mode == MODE_READY) next_mode = MODE_BLOCKED;
                else if (next_mode == MODE_SUSP_READY) next_mode = MODE_SUSP_BLOCKED;
            end
            OP_UNBLOCK: begin
                if (next_mode == MODE_BLOCKED) next_mode = MODE_READY;
                else if (next_mode == MODE_SUSP_BLOCKED) next_mode = MODE_SUSP_READY;
            end
            OP_SUSPEND: begin
                if (next_mode == MODE_READY) next_mode = MODE_SUSP_READY;
                else if (next_mode == MODE_BLOCKED) next_mode = MODE_SUSP_BLOCKED;
            end
            OP_RESUME: begin
                if (next_mode == MODE_SUSP_READY) next_mode = MODE_READY;
                else if (next_mode == MODE_SUSP_BLOCKED) next_mode = MODE_BLOCKED;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            ready_len_reg <= '0;
            wait_len_reg  <= '0;
            for (int k = 0; k < MAX_PROCS; k++) slot_used_reg[k] <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        op_reg         <= s_opcode;
                        id_reg         <= s_proc_id;
                        cls_reg        <= s_proc_class;
                        pri_reg        <= s_new_priority;
                        idx_reg        <= '0;
                        match_reg      <= 1'b0;
                        free_found_reg <= 1'b0;
                        state_reg      <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (slot_used_reg[cur_i] && slot_ident_reg[cur_i] == id_reg
                        && !match_reg) begin
                        match_reg <= 1'b1;
                        slot_reg  <= cur_i;
                    end
                    if (!slot_used_reg[cur_i] && !free_found_reg) begin
                        free_found_reg <= 1'b1;
                        free_reg       <= cur_i;
                    end
                    if (idx_reg == LAST) state_reg <= S_DECIDE;
                    else idx_reg <= idx_inc;
                end
                S_DECIDE: begin
                    old_mode_reg <= slot_mode_reg[slot_reg];
                    drop_hit_reg <= 1'b0;
                    if (op_reg == OP_CREATE) begin
                        new_mode_reg <= MODE_READY;
                        if (match_reg) begin
                            status_reg <= ST_DUPLICATE;
                            idx_reg    <= '0;
                            state_reg  <= S_OUT;
                        end else if (!free_found_reg) begin
                            status_reg <= ST_FULL;
                            idx_reg    <= '0;
                            state_reg  <= S_OUT;
                        end else begin
                            status_reg               <= ST_OK;
                            slot_used_reg[free_reg]  <= 1'b1;
                            slot_ident_reg[free_reg] <= id_reg;
                            slot_kind_reg[free_reg]  <= cls_reg;
                            slot_mode_reg[free_reg]  <= MODE_READY;
                            slot_prio_reg[free_reg]  <= pri_reg;
                            slot_reg                 <= free_reg;
                            idx_reg                  <= ready_len_reg;
                            state_reg                <= S_INSERT;
                        end
                    end else begin
                        new_mode_reg <= next_mode;
                        idx_reg      <= '0;
                        if (!match_reg) begin
                            status_reg <= ST_NOT_FOUND;
                            state_reg  <= S_OUT;
                        end else begin
                            status_reg   <= ST_OK;
                            del_mode_reg <= slot_mode_reg[slot_reg];
                            del_kind_reg <= slot_kind_reg[slot_reg];
                            del_prio_reg <= slot_prio_reg[slot_reg];
                            case (op_reg)
                                OP_QUERY: state_reg <= S_OUT;
                                OP_SETPRIO: begin
                                    if (slot_mode_reg[slot_reg] == MODE_READY) begin
                                        state_reg <= S_DROP;
                                    end else begin
                                        slot_prio_reg[slot_reg] <= pri_reg;
                                        state_reg <= S_OUT;
                                    end
                                end
                                default: state_reg <= S_DROP;
                            endcase
                        end
                    end
                end
                S_DROP: begin
                    // shift the tail of the list over the removed entry
                    if (drop_hit && !drop_last) begin
                        if (drop_sel_ready) ready_order_reg[cur_i] <= ready_order_reg[nxt_i];
                        else wait_order_reg[cur_i] <= wait_order_reg[nxt_i];
                    end
                    drop_hit_reg <= drop_hit;
                    if (drop_last) begin
                        if (drop_hit) begin
                            if (drop_sel_ready) ready_len_reg <= ready_len_reg - CW'(1);
                            else wait_len_reg <= wait_len_reg - CW'(1);
                        end
                        if (op_reg == OP_DELETE) begin
                            slot_used_reg[slot_reg] <= 1'b0;
                            state_reg <= S_OUT;
                        end else begin
                            slot_mode_reg[slot_reg] <= new_mode_reg;
                            if (op_reg == OP_SETPRIO) slot_prio_reg[slot_reg] <= pri_reg;
                            idx_reg <= (drop_hit && drop_sel_ready)
                                       ? ready_len_reg - CW'(1) : ready_len_reg;
                            state_reg <= S_INSERT;
                        end
                    end else begin
                        idx_reg <= idx_inc;
                    end
                end
                S_INSERT: begin
                    if (new_mode_reg == MODE_READY) begin
                        // walk from the tail; stop behind the last entry with prio <= p
                        if (idx_reg != '0 && slot_prio_reg[ready_order_reg[prv_i]]
                                             > slot_prio_reg[slot_reg]) begin
                            ready_order_reg[cur_i] <= ready_order_reg[prv_i];
                            idx_reg <= idx_dec;
                        end else begin
                            ready_order_reg[cur_i] <= slot_reg;
                            ready_len_reg <= ready_len_reg + CW'(1);
                            state_reg <= S_OUT;
                        end
                    end else begin
                        wait_order_reg[wait_len_reg[IW-1:0]] <= slot_reg;
                        wait_len_reg <= wait_len_reg + CW'(1);
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (m_ready) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_OUT);

    always_comb begin
        m_status             = status_reg;
        m_entry_state_out    = '0;
        m_entry_class_out    = 1'b0;
        m_entry_priority_out = '0;
        if (status_reg == ST_OK) begin
            if (op_reg == OP_DELETE) begin
                m_entry_state_out    = del_mode_reg;
                m_entry_class_out    = del_kind_reg;
                m_entry_priority_out = del_prio_reg;
            end else begin
                m_entry_state_out    = slot_mode_reg[slot_reg];
                m_entry_class_out    = slot_kind_reg[slot_reg];
                m_entry_priority_out = slot_prio_reg[slot_reg];
            end
        end
    end

    assign m_head_valid  = (ready_len_reg != '0);
    assign m_head_id     = m_head_valid ? slot_ident_reg[ready_order_reg[0]] : 8'd0;
    assign m_ready_total = 5'(ready_len_reg);
    assign m_wait_total  = 5'(wait_len_reg);

    `PQM_ASSERT(a_len_bound, aclk, aresetn,
        (32'(ready_len_reg) + 32'(wait_len_reg) <= 32'(MAX_PROCS)), "queue lengths overflow")
    `PQM_ASSERT(a_one_at_a_time, aclk, aresetn,
        (s_valid && s_ready) |=> !s_ready, "command taken while busy")
    `PQM_ASSERT(a_fail_no_change, aclk, aresetn,
        (m_valid && m_status != ST_OK) |-> $stable(ready_len_reg), "failed command moved queue")

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Command-level check of the process queue manager: a scoreboard table with
// a priority-ordered ready list and a FIFO wait list predicts every result
// word; directed corner commands are followed by random command streams.
// ----------------------------------------------------------------------------
module tb_top
    import pqm_pkg::*;
();

    localparam int NPROC     = MAX_PROCS_DEF;
    localparam int CYC_LIMIT = 1500000;

    typedef struct packed {
        logic [2:0]        op;
        logic [7:0]        id;
        logic              cls;
        logic signed [7:0] pri;
    } cmd_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [1:0]        mode;
        logic              cls;
        logic signed [7:0] pri;
        logic              hvalid;
        logic [7:0]        hid;
        logic [4:0]        rtotal;
        logic [4:0]        wtotal;
    } rsp_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [2:0] s_opcode = '0;
    logic [7:0] s_proc_id = '0;
    logic s_proc_class = 1'b0;
    logic signed [7:0] s_new_priority = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [1:0] m_status, m_entry_state_out;
    logic m_entry_class_out, m_head_valid;
    logic signed [7:0] m_entry_priority_out;
    logic [7:0] m_head_id;
    logic [4:0] m_ready_total, m_wait_total;

    process_queue_manager_unit uut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // scoreboard copy of the process table
    logic              pt_used  [NPROC];
    logic [7:0]        pt_id    [NPROC];
    logic              pt_cls   [NPROC];
    logic [1:0]        pt_mode  [NPROC];
    logic signed [7:0] pt_pri   [NPROC];
    int                run_list[$];
    int                wait_list[$];

    cmd_t pending_cmds[$];
    rsp_t expected_rsp[$];
    int   errors = 0;
    int   n_rsp = 0;
    int   n_sent = 0;
    int   cycles = 0;
    int   send_idle_pct = 22;
    int   recv_idle_pct = 72;
    int   hold_off = 0;
    bit   pause_send = 1'b0;

    // accepted flag from the last rising edge, for the driver
    logic s_ready_q = 1'b0;

    function automatic int find_entry(logic [7:0] id);
        for (int i = 0; i < NPROC; i++)
            if (pt_used[i] && pt_id[i] == id) return i;
        return -1;
    endfunction

    function automatic void pull_entry(int s);
        if (pt_mode[s] == MODE_READY) begin
            foreach (run_list[i])
                if (run_list[i] == s) begin
                    run_list.delete(i);
                    break;
                end
        end else begin
            foreach (wait_list[i])
                if (wait_list[i] == s) begin
                    wait_list.delete(i);
                    break;
                end
        end
    endfunction

    function automatic void put_entry(int s);
        int pos;
        if (pt_mode[s] == MODE_READY) begin
            pos = 0;
            while (pos < run_list.size() && pt_pri[run_list[pos]] <= pt_pri[s]) pos++;
            run_list.insert(pos, s);
        end else begin
            wait_list.push_back(s);
        end
    endfunction

    function automatic rsp_t schedule_cmd(cmd_t c);
        rsp_t r;
        int s, f;
        logic [1:0] m;
        r = '0;
        r.status = ST_OK;
        s = find_entry(c.id);
        if (c.op == OP_CREATE) begin
            if (s >= 0) r.status = ST_DUPLICATE;
            else begin
                f = -1;
                for (int i = NPROC - 1; i >= 0; i--) if (!pt_used[i]) f = i;
                if (f < 0) r.status = ST_FULL;
                else begin
                    pt_used[f] = 1'b1; pt_id[f] = c.id; pt_cls[f] = c.cls;
                    pt_mode[f] = MODE_READY; pt_pri[f] = c.pri;
                    put_entry(f);
                    s = f;
                end
            end
        end else if (s < 0) begin
            r.status = ST_NOT_FOUND;
        end else begin
            m = pt_mode[s];
            case (c.op)
                OP_DELETE: begin
                    r.mode = m; r.cls = pt_cls[s]; r.pri = pt_pri[s];
                    pull_entry(s);
                    pt_used[s] = 1'b0;
                end
                OP_BLOCK, OP_UNBLOCK, OP_SUSPEND, OP_RESUME: begin
                    pull_entry(s);
                    case (c.op)
                        OP_BLOCK:   m = (m == MODE_READY) ? MODE_BLOCKED :
                                        (m == MODE_SUSP_READY) ? MODE_SUSP_BLOCKED : m;
                        OP_UNBLOCK: m = (m == MODE_BLOCKED) ? MODE_READY :
                                        (m == MODE_SUSP_BLOCKED) ? MODE_SUSP_READY : m;
                        OP_SUSPEND: m = (m == MODE_READY) ? MODE_SUSP_READY :
                                        (m == MODE_BLOCKED) ? MODE_SUSP_BLOCKED : m;
                        default:    m = (m == MODE_SUSP_READY) ? MODE_READY :
                                        (m == MODE_SUSP_BLOCKED) ? MODE_BLOCKED : m;
                    endcase
                    pt_mode[s] = m;
                    put_entry(s);
                end
                OP_SETPRIO: begin
                    if (m == MODE_READY) begin
                        pull_entry(s);
                        pt_pri[s] = c.pri;
                        put_entry(s);
                    end else begin
                        pt_pri[s] = c.pri;
                    end
                end
                default: ;
            endcase
        end
        if (r.status == ST_OK && c.op != OP_DELETE) begin
            r.mode = pt_mode[s]; r.cls = pt_cls[s]; r.pri = pt_pri[s];
        end
        r.hvalid = run_list.size() > 0;
        r.hid = r.hvalid ? pt_id[run_list[0]] : 8'd0;
        r.rtotal = 5'(run_list.size());
        r.wtotal = 5'(wait_list.size());
        return r;
    endfunction

    // driver
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || s_ready_q) begin
                if (pending_cmds.size() > 0 && !pause_send &&
                    $urandom_range(99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    {s_opcode, s_proc_id, s_proc_class, s_new_priority} <=
                        pending_cmds.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver, with its own hold-off countdown
    always @(negedge aclk) begin
        if (aresetn) begin
            if (hold_off > 0) begin
                m_ready <= 1'b0;
                hold_off <= hold_off - 1;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        rsp_t got, exp_r;
        cmd_t c;
        cycles <= cycles + 1;
        s_ready_q <= s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            c = {s_opcode, s_proc_id, s_proc_class, s_new_priority};
            expected_rsp.push_back(schedule_cmd(c));
            n_sent <= n_sent + 1;
        end
        if (aresetn && m_valid && m_ready) begin
            got = {m_status, m_entry_state_out, m_entry_class_out, m_entry_priority_out,
                   m_head_valid, m_head_id, m_ready_total, m_wait_total};
            n_rsp <= n_rsp + 1;
            if (expected_rsp.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors <= errors + 1;
            end else begin
                exp_r = expected_rsp.pop_front();
                if (got !== exp_r) begin
                    $display("%0t: mismatch", $time);
                    $display("  exp st=%0d md=%0d cl=%0d pr=%0d hv=%0d hid=%0d rt=%0d wt=%0d",
                             exp_r.status, exp_r.mode, exp_r.cls, exp_r.pri,
                             exp_r.hvalid, exp_r.hid, exp_r.rtotal, exp_r.wtotal);
                    $display("  got st=%0d md=%0d cl=%0d pr=%0d hv=%0d hid=%0d rt=%0d wt=%0d",
                             got.status, got.mode, got.cls, got.pri,
                             got.hvalid, got.hid, got.rtotal, got.wtotal);
                    errors <= errors + 1;
                end
            end
        end
        if (cycles >= CYC_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic cmd_t mk(logic [2:0] op, logic [7:0] id, logic cls,
                                logic signed [7:0] pri);
        cmd_t c;
        c.op = op; c.id = id; c.cls = cls; c.pri = pri;
        return c;
    endfunction

    // ids kept in a small pool so commands usually hit existing entries
    function automatic cmd_t rand_cmd();
        logic [7:0] id;
        logic [2:0] op;
        id = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(23) * 11);
        op = ($urandom_range(3) == 0) ? OP_CREATE : 3'($urandom);
        return mk(op, id, 1'($urandom), 8'($urandom));
    endfunction

    task automatic wait_drained();
        while (pending_cmds.size() > 0 || s_valid || expected_rsp.size() > 0)
            @(posedge aclk);
    endtask

    initial begin
        for (int i = 0; i < NPROC; i++) begin
            pt_used[i] = 1'b0; pt_id[i] = '0; pt_cls[i] = 1'b0;
            pt_mode[i] = MODE_READY; pt_pri[i] = '0;
        end
        repeat (9) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // directed: extremes, every op, duplicate, not found, equal-priority ties
        pending_cmds.push_back(mk(OP_QUERY, 8'd5, 1'b0, 8'sd0));
        pending_cmds.push_back(mk(OP_CREATE, 8'd0, 1'b0, 8'sd127));
        pending_cmds.push_back(mk(OP_CREATE, 8'd255, 1'b1, -8'sd128));
        pending_cmds.push_back(mk(OP_CREATE, 8'd255, 1'b0, 8'sd3));
        pending_cmds.push_back(mk(OP_CREATE, 8'd7, 1'b1, -8'sd128));
        pending_cmds.push_back(mk(OP_BLOCK, 8'd255, 1'b0, 8'sd0));
        pending_cmds.push_back(mk(OP_BLOCK, 8'd255, 1'b0, 8'sd0));
        pending_cmds.push_back(mk(OP_SUSPEND, 8'd255, 1'b0, 8'sd0));
        pending_cmds.push_back(mk(OP_SETPRIO, 8'd255, 1'b0, 8'sd127));
        pending_cmds.push_back(mk(OP_UNBLOCK, 8'd255, 1'b0, 8'sd0));
        pending_cmds.push_back(mk(OP_RESUME, 8'd255, 1'b0, 8'sd0));
        pending_cmds.push_back(mk(OP_RESUME, 8'd7, 1'b0, 8'sd0));
        pending_cmds.push_back(mk(OP_SETPRIO, 8'd0, 1'b0, -8'sd128));
        pending_cmds.push_back(mk(OP_SUSPEND, 8'd7, 1'b0, 8'sd0));
        pending_cmds.push_back(mk(OP_QUERY, 8'd7, 1'b0, 8'sd0));
        pending_cmds.push_back(mk(OP_DELETE, 8'd7, 1'b0, 8'sd0));
        pending_cmds.push_back(mk(OP_DELETE, 8'd0, 1'b0, 8'sd0));
        pending_cmds.push_back(mk(OP_DELETE, 8'd0, 1'b0, 8'sd0));
        pending_cmds.push_back(mk(OP_UNBLOCK, 8'd99, 1'b0, 8'sd0));
        for (int i = 1; i <= 17; i++)
            pending_cmds.push_back(mk(OP_CREATE, 8'(i * 13), 1'($urandom), 8'sd0));
        pending_cmds.push_back(mk(OP_CREATE, 8'd13, 1'b0, 8'sd0));
        wait_drained();

        // sender pauses while the deletes are queued, then resumes
        pause_send = 1'b1;
        for (int i = 1; i <= 17; i++)
            pending_cmds.push_back(mk(OP_DELETE, 8'(i * 13), 1'b0, 8'sd0));
        repeat (40) @(posedge aclk);
        pause_send = 1'b0;
        wait_drained();

        // long receiver hold-off while commands keep coming
        hold_off = 300;
        for (int i = 0; i < 60; i++) pending_cmds.push_back(rand_cmd());
        for (int ph = 0; ph < 3; ph++) begin
            wait_drained();
            send_idle_pct = (ph == 0) ? 22 : (ph == 1) ? 72 : 0;
            recv_idle_pct = (ph == 0) ? 72 : (ph == 1) ? 22 : 0;
            for (int i = 0; i < 340; i++) pending_cmds.push_back(rand_cmd());
        end
        wait_drained();
        repeat (3 * NPROC + 10) @(posedge aclk);

        $display("sent %0d commands, checked %0d results", n_sent, n_rsp);
        $display("covered all opcodes, full table, ties, stalls and long hold-offs");
        if (errors == 0 && expected_rsp.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
